@@ hw/rtl/fvcw_pkg.sv @@
// ---------------------------------------------------------------------------
// fvcw_pkg: shared types and constants of the flow vector color wheel
// Widths, cell payload, CORDIC angle table and the 55-entry wheel.
// ---------------------------------------------------------------------------
package fvcw_pkg;

    localparam int FLOW_BITS  = 16;
    localparam int WHEEL_SIZE = 55;
    localparam int CORDIC_N   = 15;
    localparam int NCELL      = (FLOW_BITS > CORDIC_N) ? FLOW_BITS : CORDIC_N;
    localparam int IDX_W      = $clog2(NCELL);
    localparam int CW         = 36;            // CORDIC datapath width
    localparam int SQ_W       = 2 * FLOW_BITS; // width of u*u+v*v
    localparam int RAD_W      = FLOW_BITS;
    localparam int COL_W      = 24;            // 255 * 2^16 fits
    localparam int PROD_W     = RAD_W + COL_W;
    localparam int DSH        = 16 + FLOW_BITS - 1;

    typedef struct packed {
        logic                   vld;
        logic                   in_unit;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic [15:0]            z;
        logic [SQ_W-1:0]        n;
        logic [SQ_W-1:0]        r;
    } t_cell;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef struct packed {
        logic       vld;
        logic       beyond;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix;

    function automatic logic [15:0] atan_turn(input logic [IDX_W-1:0] i);
        logic [15:0] a;
        case (i)
            0: a = 16'd8192;
            1: a = 16'd4836;
            2: a = 16'd2555;
            3: a = 16'd1297;
            4: a = 16'd651;
            5: a = 16'd326;
            6: a = 16'd163;
            7: a = 16'd81;
            8: a = 16'd41;
            9: a = 16'd20;
            10: a = 16'd10;
            11: a = 16'd5;
            12: a = 16'd3;
            13: a = 16'd1;
            14: a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

    // Wheel entry k as {r, g, b}: ramps of 15, 6, 4, 11, 13 and 6 entries,
    // each step floor(255 * j / ramp); out-of-range entries map to entry 0.
    function automatic t_rgb wheel_entry(input logic [5:0] k);
        t_rgb c;
        case (k)
            6'd0:  c = {8'd255, 8'd0,   8'd0};
            6'd1:  c = {8'd255, 8'd17,  8'd0};
            6'd2:  c = {8'd255, 8'd34,  8'd0};
            6'd3:  c = {8'd255, 8'd51,  8'd0};
            6'd4:  c = {8'd255, 8'd68,  8'd0};
            6'd5:  c = {8'd255, 8'd85,  8'd0};
            6'd6:  c = {8'd255, 8'd102, 8'd0};
            6'd7:  c = {8'd255, 8'd119, 8'd0};
            6'd8:  c = {8'd255, 8'd136, 8'd0};
            6'd9:  c = {8'd255, 8'd153, 8'd0};
            6'd10: c = {8'd255, 8'd170, 8'd0};
            6'd11: c = {8'd255, 8'd187, 8'd0};
            6'd12: c = {8'd255, 8'd204, 8'd0};
            6'd13: c = {8'd255, 8'd221, 8'd0};
            6'd14: c = {8'd255, 8'd238, 8'd0};
            6'd15: c = {8'd255, 8'd255, 8'd0};
            6'd16: c = {8'd213, 8'd255, 8'd0};
            6'd17: c = {8'd170, 8'd255, 8'd0};
            6'd18: c = {8'd128, 8'd255, 8'd0};
            6'd19: c = {8'd85,  8'd255, 8'd0};
            6'd20: c = {8'd43,  8'd255, 8'd0};
            6'd21: c = {8'd0,   8'd255, 8'd0};
            6'd22: c = {8'd0,   8'd255, 8'd63};
            6'd23: c = {8'd0,   8'd255, 8'd127};
            6'd24: c = {8'd0,   8'd255, 8'd191};
            6'd25: c = {8'd0,   8'd255, 8'd255};
            6'd26: c = {8'd0,   8'd232, 8'd255};
            6'd27: c = {8'd0,   8'd209, 8'd255};
            6'd28: c = {8'd0,   8'd186, 8'd255};
            6'd29: c = {8'd0,   8'd163, 8'd255};
            6'd30: c = {8'd0,   8'd140, 8'd255};
            6'd31: c = {8'd0,   8'd116, 8'd255};
            6'd32: c = {8'd0,   8'd93,  8'd255};
            6'd33: c = {8'd0,   8'd70,  8'd255};
            6'd34: c = {8'd0,   8'd47,  8'd255};
            6'd35: c = {8'd0,   8'd24,  8'd255};
            6'd36: c = {8'd0,   8'd0,   8'd255};
            6'd37: c = {8'd19,  8'd0,   8'd255};
            6'd38: c = {8'd39,  8'd0,   8'd255};
            6'd39: c = {8'd58,  8'd0,   8'd255};
            6'd40: c = {8'd78,  8'd0,   8'd255};
            6'd41: c = {8'd98,  8'd0,   8'd255};
            6'd42: c = {8'd117, 8'd0,   8'd255};
            6'd43: c = {8'd137, 8'd0,   8'd255};
            6'd44: c = {8'd156, 8'd0,   8'd255};
            6'd45: c = {8'd176, 8'd0,   8'd255};
            6'd46: c = {8'd196, 8'd0,   8'd255};
            6'd47: c = {8'd215, 8'd0,   8'd255};
            6'd48: c = {8'd235, 8'd0,   8'd255};
            6'd49: c = {8'd255, 8'd0,   8'd255};
            6'd50: c = {8'd255, 8'd0,   8'd213};
            6'd51: c = {8'd255, 8'd0,   8'd170};
            6'd52: c = {8'd255, 8'd0,   8'd128};
            6'd53: c = {8'd255, 8'd0,   8'd85};
            6'd54: c = {8'd255, 8'd0,   8'd43};
            default: c = {8'd255, 8'd0,   8'd0};
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/flow_vector_color_wheel.sv @@
// ---------------------------------------------------------------------------
// flow_vector_color_wheel: optical-flow vector to BGR color
// Angle picks a hue on a 55-entry wheel, magnitude sets saturation.
// ---------------------------------------------------------------------------
// Takes one flow word per clock and returns one color word per clock, in
// order. A word flows through one squaring stage, a chain of 16 identical
// cells (each does one digit of the integer square root for the magnitude,
// and the first 15 also do one CORDIC rotation for the angle), and three
// color stages, then an output register. The whole pipeline advances when
// the output register is empty or being drained, so s_axis_tready follows
// m_axis_tready; with a ready sink the block accepts one word every cycle.
// Input tdata: flow_u [15:0], flow_v [31:16] (signed Q1.15).
// Output tdata: blue [7:0], green [15:8], red [23:16]; tuser: beyond_unit,
// set when the magnitude exceeded 1 and the hue was dimmed by 0.75.
// ---------------------------------------------------------------------------
module flow_vector_color_wheel
    import fvcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // flow_u [15:0], flow_v [31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // blue [7:0], green [15:8], red [23:16]
    output logic        m_axis_tuser    // beyond_unit [0]
);

    logic en;
    // input stage: hold flow and its squares
    logic                        r_s0_vld;
    logic signed [FLOW_BITS-1:0] r_u, r_v;
    logic [SQ_W-1:0]             r_uu, r_vv;
    t_cell                       head;
    t_cell                       chain [NCELL+1];
    logic [SQ_W-1:0]             sq;
    logic signed [CW-1:0]        xs, ys;
    t_pix                        pix;
    logic                        r_o_vld, r_o_beyond;
    logic [23:0]                 r_o_data;

    // advance everything unless a finished word waits on a stalled sink
    assign en            = !r_o_vld || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u  <= s_axis_tdata[FLOW_BITS-1:0];
            r_v  <= s_axis_tdata[16 +: FLOW_BITS];
            r_uu <= SQ_W'($signed(s_axis_tdata[FLOW_BITS-1:0])
                          * $signed(s_axis_tdata[FLOW_BITS-1:0]));
            r_vv <= SQ_W'($signed(s_axis_tdata[16 +: FLOW_BITS])
                          * $signed(s_axis_tdata[16 +: FLOW_BITS]));
        end
    end

    // scale to 32-bit range, pre-rotate by a half turn when u is negative
    always_comb begin
        sq  = r_uu + r_vv;
        xs  = CW'(r_u) <<< (32 - FLOW_BITS);
        ys  = CW'(r_v) <<< (32 - FLOW_BITS);
        head.vld     = r_s0_vld;
        head.in_unit = sq <= (SQ_W'(1) << (2 * (FLOW_BITS - 1)));
        head.n       = sq;
        head.r       = '0;
        if (xs[CW-1]) begin
            head.x = -xs;
            head.y = -ys;
            head.z = 16'h8000;
        end else begin
            head.x = xs;
            head.y = ys;
            head.z = 16'h0000;
        end
    end

    assign chain[0] = head;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        fvcw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_idx   (IDX_W'(g)),
            .i_d     (chain[g]),
            .o_d     (chain[g+1])
        );
    end

    fvcw_color u_color (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (chain[NCELL].vld),
        .i_inside (chain[NCELL].in_unit),
        .i_phase  (chain[NCELL].z),
        .i_rad    (chain[NCELL].in_unit ? chain[NCELL].r[RAD_W-1:0] : '0),
        .o_pix    (pix)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= pix.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data   <= {pix.red, pix.green, pix.blue};
            r_o_beyond <= pix.beyond;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_beyond;

endmodule

@@ hw/rtl/fvcw_cell.sv @@
// ---------------------------------------------------------------------------
// fvcw_cell: one cell of the angle/magnitude chain
// A root digit per cell; cells under CORDIC_N add a CORDIC vectoring rotation.
// ---------------------------------------------------------------------------
module fvcw_cell
    import fvcw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cell            i_d,
    output t_cell            o_d
);

    t_cell r_q, n_q;
    logic [SQ_W-1:0] bit_v, trial;

    always_comb begin
        n_q   = i_d;
        bit_v = SQ_W'(1) << (SQ_W'(2 * FLOW_BITS - 2) - SQ_W'({i_idx, 1'b0}));
        trial = i_d.r + bit_v;
        // rotate toward the axis; hold once y reaches zero
        if (32'(i_idx) < CORDIC_N) begin
            if (!i_d.y[CW-1] && i_d.y != '0) begin
                n_q.x = i_d.x + (i_d.y >>> i_idx);
                n_q.y = i_d.y - (i_d.x >>> i_idx);
                n_q.z = i_d.z + atan_turn(i_idx);
            end else if (i_d.y[CW-1]) begin
                n_q.x = i_d.x - (i_d.y >>> i_idx);
                n_q.y = i_d.y + (i_d.x >>> i_idx);
                n_q.z = i_d.z - atan_turn(i_idx);
            end
        end
        // one root digit
        if (32'(i_idx) < FLOW_BITS) begin
            if (i_d.n >= trial) begin
                n_q.n = i_d.n - trial;
                n_q.r = (i_d.r >> 1) + bit_v;
            end else begin
                n_q.r = i_d.r >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.vld <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_d = r_q;

endmodule

@@ hw/rtl/fvcw_color.sv @@
// ---------------------------------------------------------------------------
// fvcw_color: hue interpolation and saturation
// Phase to wheel index, blend of neighbor entries, desaturate or dim.
// ---------------------------------------------------------------------------
module fvcw_color
    import fvcw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic             i_inside,
    input  logic [15:0]      i_phase,
    input  logic [RAD_W-1:0] i_rad,
    output t_pix             o_pix
);

    localparam logic [COL_W-1:0] FULL = COL_W'(255 * 65536);

    logic             r_a_vld, r_a_in;
    logic [5:0]       r_a_k0;
    logic [15:0]      r_a_f;
    logic [RAD_W-1:0] r_a_rad;
    logic             r_b_vld, r_b_in;
    logic [COL_W-1:0] r_b_c [3];
    logic [RAD_W-1:0] r_b_rad;
    logic             r_c_vld, r_c_in;
    logic [COL_W-1:0] r_c_c [3];
    logic [PROD_W-1:0] r_c_p [3];

    logic [21:0]      n_k;
    logic [5:0]       k1;
    t_rgb             e0, e1;
    logic [7:0]       c0 [3];
    logic [7:0]       c1 [3];
    logic [COL_W-1:0] n_c [3];
    logic [7:0]       res [3];

    always_comb begin
        n_k = 22'(i_phase) * 22'd54;
        k1  = (r_a_k0 + 6'd1 >= 6'(WHEEL_SIZE)) ? 6'd0 : r_a_k0 + 6'd1;
        e0  = wheel_entry(r_a_k0);
        e1  = wheel_entry(k1);
        c0[0] = e0.r; c0[1] = e0.g; c0[2] = e0.b;
        c1[0] = e1.r; c1[1] = e1.g; c1[2] = e1.b;
        for (int ch = 0; ch < 3; ch++) begin
            n_c[ch] = COL_W'(25'(c0[ch]) * (25'h10000 - 25'(r_a_f))
                           + 25'(c1[ch]) * 25'(r_a_f));
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            logic [PROD_W:0] up;
            logic [COL_W+1:0] dim;
            up  = ({1'b0, r_c_p[ch]} + (PROD_W+1)'((64'd1 << DSH) - 64'd1)) >> DSH;
            dim = ((COL_W+2)'(r_c_c[ch]) * (COL_W+2)'(3)) >> 18;
            if (r_c_in) begin
                res[ch] = (up >= (PROD_W+1)'(255)) ? 8'd0 : 8'd255 - up[7:0];
            end else begin
                res[ch] = dim[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_in  <= i_inside;
            r_a_k0  <= n_k[21:16];
            r_a_f   <= n_k[15:0];
            r_a_rad <= i_rad;
            r_b_in  <= r_a_in;
            r_b_rad <= r_a_rad;
            r_c_in  <= r_b_in;
            for (int ch = 0; ch < 3; ch++) begin
                r_b_c[ch] <= n_c[ch];
                r_c_c[ch] <= r_b_c[ch];
                r_c_p[ch] <= PROD_W'(r_b_rad) * PROD_W'(FULL - r_b_c[ch]);
            end
        end
    end

    assign o_pix.vld    = r_c_vld;
    assign o_pix.beyond = !r_c_in;
    assign o_pix.red    = res[0];
    assign o_pix.green  = res[1];
    assign o_pix.blue   = res[2];

endmodule

@@ dv/flow_vector_color_wheel_checker.sv @@
// ---------------------------------------------------------------------------
// flow_vector_color_wheel_checker: color prediction and compare
// Watches both stream channels, predicts each pixel color from the flow word
// and compares it with the next color word in order.
// ---------------------------------------------------------------------------
module flow_vector_color_wheel_checker
    import fvcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,
    input  logic        i_out_user,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic       beyond;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    t_color pending_colors[$];
    int     fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_colors.size();

    function automatic longint shr_floor(longint a, int s);
        return a >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Hue entry k as {red, green, blue}; index past the end wraps to entry 0.
    function automatic void hue_entry(int k, output int r, output int g, output int b);
        if (k >= WHEEL_SIZE) k = 0;
        r = 0; g = 0; b = 0;
        if (k < 15) begin
            r = 255; g = 255 * k / 15;
        end else if (k < 21) begin
            r = 255 - 255 * (k - 15) / 6; g = 255;
        end else if (k < 25) begin
            g = 255; b = 255 * (k - 21) / 4;
        end else if (k < 36) begin
            g = 255 - 255 * (k - 25) / 11; b = 255;
        end else if (k < 49) begin
            b = 255; r = 255 * (k - 36) / 13;
        end else begin
            b = 255 - 255 * (k - 49) / 6; r = 255;
        end
    endfunction

    // Vectoring rotations give the angle in 2^-16 turn.
    function automatic int flow_phase(longint u, longint v);
        int     steps[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
                              3, 1, 1};
        longint x, y, nx, ny;
        int     z;
        x = u <<< (32 - FLOW_BITS);
        y = v <<< (32 - FLOW_BITS);
        z = 0;
        if (u == 0 && v == 0) return 0;
        if (x < 0) begin
            x = -x; y = -y; z = 32768;
        end
        for (int i = 0; i < 15; i++) begin
            if (y == 0) break;
            if (y > 0) begin
                nx = x + shr_floor(y, i); ny = y - shr_floor(x, i); z += steps[i];
            end else begin
                nx = x - shr_floor(y, i); ny = y + shr_floor(x, i); z -= steps[i];
            end
            x = nx; y = ny;
        end
        return z & 16'hFFFF;
    endfunction

    function automatic t_color predict_color(logic [31:0] flow);
        longint          u, v;
        longint unsigned sq, rad, c, up;
        longint unsigned chan[3];
        int              c0[3], c1[3];
        int              p, kk, k0, k1, f;
        logic            in_unit;
        t_color          res;
        u = longint'($signed(flow[15:0]));
        v = longint'($signed(flow[31:16]));
        sq = u * u + v * v;
        in_unit = sq <= (64'd1 << (2 * (FLOW_BITS - 1)));
        rad = in_unit ? int_sqrt(sq) : 0;
        p = flow_phase(u, v);
        kk = p * (WHEEL_SIZE - 1);
        k0 = kk >> 16;
        k1 = (k0 + 1 >= WHEEL_SIZE) ? 0 : k0 + 1;
        f = kk & 16'hFFFF;
        hue_entry(k0, c0[0], c0[1], c0[2]);
        hue_entry(k1, c1[0], c1[1], c1[2]);
        for (int ch = 0; ch < 3; ch++) begin
            c = longint'(c0[ch]) * (65536 - f) + longint'(c1[ch]) * f;
            if (in_unit) begin
                up = (rad * (255 * 65536 - c) + (64'd1 << DSH) - 1) >> DSH;
                chan[ch] = (up >= 255) ? 0 : 255 - up;
            end else begin
                chan[ch] = (c * 3) >> 18;
            end
        end
        res.red    = chan[0][7:0];
        res.green  = chan[1][7:0];
        res.blue   = chan[2][7:0];
        res.beyond = !in_unit;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_color want, got;
        if (!i_rst_n) begin
            fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                pending_colors.push_back(predict_color(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = {i_out_user, i_out_data[23:16], i_out_data[15:8], i_out_data[7:0]};
                if (pending_colors.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected color word %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = pending_colors.pop_front();
                    if (want !== got) begin
                        if (fail_count < 10)
                            $display("color word: expected b=%0d g=%0d r=%0d x=%0d, got b=%0d g=%0d r=%0d x=%0d",
                                     want.blue, want.green, want.red, want.beyond,
                                     got.blue, got.green, got.red, got.beyond);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ dv/tb_flow_vector_color_wheel.sv @@
// ---------------------------------------------------------------------------
// tb_flow_vector_color_wheel: stream test of the flow vector color wheel
// Drives directed and random flow words under varying back-pressure; the
// checker predicts every color word and counts mismatches.
// ---------------------------------------------------------------------------
module tb_flow_vector_color_wheel;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // flow_u [15:0], flow_v [31:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // blue [7:0], green [15:8], red [23:16]
    logic        m_axis_tuser;        // beyond_unit [0]

    int fail_count;
    int pending_count;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles   = 0;

    always #10 i_clk = ~i_clk;

    flow_vector_color_wheel dut (.*);

    flow_vector_color_wheel_checker color_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Stall the sink at random, re-rolled every cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: count cycles with no word moved on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (i_rst_n && idle_cycles > WATCHDOG_LIMIT) begin
            $display("flow_vector_color_wheel: mismatch");
            $finish;
        end
    end

    // Hold one flow word until accepted; idle the source between words.
    task automatic send_flow(logic [15:0] u, logic [15:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, u};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Mostly in-range vectors, some near the unit circle, some full scale.
    task automatic send_random_flow();
        int mode;
        int ang;
        logic [15:0] u, v;
        mode = $urandom_range(9);
        if (mode < 5) begin
            u = 16'($signed($urandom_range(46340)) - 23170);
            v = 16'($signed($urandom_range(46340)) - 23170);
        end else if (mode < 7) begin
            u = 16'($urandom);
            v = 16'($urandom);
        end else if (mode < 9) begin
            ang = $urandom_range(7);
            u = 16'($urandom_range(8));
            v = 16'($urandom_range(32767));
            case (ang)
                0: send_flow(16'd32767 - u, v);
                1: send_flow(v, 16'd32767 - u);
                2: send_flow(-v, 16'd32767 - u);
                3: send_flow(16'h8001 + u, v);
                4: send_flow(16'd23170 - u, -(16'd23170 - u));
                5: send_flow(u, -v);
                6: send_flow(-u, v);
                default: send_flow(16'd23170 + u, 16'd23170);
            endcase
            return;
        end else begin
            u = 16'($signed($urandom_range(64)) - 32);
            v = 16'($signed($urandom_range(64)) - 32);
        end
        send_flow(u, v);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, axes, full-scale corners, wheel wrap, unit circle.
        send_flow(16'd0, 16'd0);
        send_flow(16'd32767, 16'd0);
        send_flow(16'h8000, 16'd0);
        send_flow(16'd0, 16'd32767);
        send_flow(16'd0, 16'h8000);
        send_flow(16'd32767, 16'd32767);
        send_flow(16'h8000, 16'h8000);
        send_flow(16'h8000, 16'd32767);
        send_flow(16'd32767, 16'h8000);
        send_flow(16'd32767, 16'hFFFF);
        send_flow(16'd32767, 16'hFF00);
        send_flow(16'd1, 16'd0);
        send_flow(16'd0, 16'd1);
        send_flow(16'hFFFF, 16'hFFFF);
        send_flow(16'd23170, 16'd23170);
        send_flow(16'd23171, 16'd23170);
        send_flow(16'd16384, 16'hC000);
        send_flow(16'h8000, 16'd1);
        send_flow(16'h8000, 16'hFFFF);
        send_flow(16'd100, 16'hFFFF);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct <= (phase == 0) ? 38 : (phase == 1) ? 75 : 0;
            recv_idle_pct <= (phase == 0) ? 75 : (phase == 1) ? 38 : 0;
            repeat (630) send_random_flow();
            // Run without gaps for a stretch inside each phase.
            send_idle_pct <= 0;
            repeat (10) send_random_flow();
        end
        s_axis_tvalid <= 1'b0;
        recv_idle_pct <= 0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("flow_vector_color_wheel: match");
        else
            $display("flow_vector_color_wheel: mismatch");
        $finish;
    end

endmodule
